/* rtl/tps_pkg.sv */
// ----------------------------------------------------------------------------
// tps_pkg: shared types, constants and list builder for the plane split core
// Holds the vertex class codes, emit-list types, sequencer states and the
// function that turns three vertex classes into the ordered emit list.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

  localparam int COORD_W        = 32;
  localparam int DIFF_W         = COORD_W + 1;
  localparam int PROD_W         = COORD_W + DIFF_W;
  localparam int QUOT_W         = DIFF_W + 1;
  localparam int DIV_STEPS      = DIFF_W;
  localparam int DIV_CNT_W      = 6;
  localparam int TOL_W          = 31;
  localparam int IDX_W          = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int MAX_EMIT       = 8;

  localparam longint unsigned LIST_DEPTH_DEF      = 65536;
  localparam int              COORD_FRAC_BITS_DEF = 16;

  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_Z   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd6;

  localparam logic SIDE_FRONT = 1'b0;
  localparam logic SIDE_BACK  = 1'b1;

  typedef enum logic [1:0] {
    CL_FRONT,
    CL_BEHIND,
    CL_ON
  } cls_t;

  typedef enum logic [2:0] {
    SRC_V0,
    SRC_V1,
    SRC_V2,
    SRC_I0,
    SRC_I1,
    SRC_I2
  } src_t;

  typedef struct packed {
    logic side;
    src_t src;
  } entry_t;

  typedef struct packed {
    logic [3:0]           count;
    entry_t [MAX_EMIT-1:0] ent;
  } plist_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_CLASS,
    S_DSETUP,
    S_DWAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic plist_t push(input plist_t l, input logic side, input src_t src);
    plist_t r;
    r = l;
    if (r.count < 4'd8) begin
      r.ent[r.count[2:0]].side = side;
      r.ent[r.count[2:0]].src  = src;
      r.count = r.count + 4'd1;
    end
    return r;
  endfunction

  // Edge i runs from vertex i to vertex i+1 (wrapping), crossing point SRC_Ii.
  function automatic plist_t build_list(input cls_t c0, input cls_t c1, input cls_t c2);
    plist_t l;
    cls_t   cl [3];
    src_t   vsrc [3];
    src_t   isrc [3];
    int     nf;
    int     nb;
    int     j;
    l = '0;
    cl[0] = c0;
    cl[1] = c1;
    cl[2] = c2;
    vsrc[0] = SRC_V0;
    vsrc[1] = SRC_V1;
    vsrc[2] = SRC_V2;
    isrc[0] = SRC_I0;
    isrc[1] = SRC_I1;
    isrc[2] = SRC_I2;
    nf = 0;
    nb = 0;
    for (int i = 0; i < 3; i++) begin
      if (cl[i] == CL_FRONT) nf++;
      if (cl[i] == CL_BEHIND) nb++;
    end
    if (nb == 3) begin
      for (int i = 0; i < 3; i++) l = push(l, SIDE_BACK, vsrc[i]);
    end else if (nf == 3 || (nf == 0 && nb == 0)) begin
      for (int i = 0; i < 3; i++) l = push(l, SIDE_FRONT, vsrc[i]);
    end else begin
      for (int i = 0; i < 3; i++) begin
        j = (i == 2) ? 0 : i + 1;
        if (cl[j] == CL_FRONT) begin
          if (cl[i] == CL_BEHIND) begin
            l = push(l, SIDE_FRONT, isrc[i]);
            l = push(l, SIDE_FRONT, vsrc[j]);
            l = push(l, SIDE_BACK, isrc[i]);
          end else begin
            l = push(l, SIDE_FRONT, vsrc[j]);
          end
        end else if (cl[j] == CL_ON) begin
          l = push(l, SIDE_FRONT, vsrc[j]);
          if (cl[i] == CL_BEHIND) l = push(l, SIDE_BACK, vsrc[j]);
        end else begin
          if (cl[i] == CL_FRONT) begin
            l = push(l, SIDE_FRONT, isrc[i]);
            l = push(l, SIDE_BACK, isrc[i]);
          end else if (cl[i] == CL_ON) begin
            l = push(l, SIDE_BACK, vsrc[i]);
          end
          l = push(l, SIDE_BACK, vsrc[j]);
        end
      end
    end
    return l;
  endfunction

endpackage

`default_nettype wire

/* rtl/triangle_plane_split_core.sv */
// ----------------------------------------------------------------------------
// triangle_plane_split_core: split one triangle against a configured plane
// Classifies three vertices by signed distance and emits front/back vertices.
// ----------------------------------------------------------------------------
// One triangle is processed at a time. After the input transfer the nine
// distance products go through one shared multiplier, then the vertices are
// classified. Each straddling edge (one or two) needs three crossing
// coordinates from the shared multiply-divide unit, and each edge without a
// crossing is skipped. Vertices then leave one per output transfer, 3 to 7
// per triangle, at best one a cycle; in_ready is high only between
// triangles, while the last results may still be waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_plane_split_core #(
  parameter longint unsigned LIST_DEPTH      = tps_pkg::LIST_DEPTH_DEF,
  parameter int              COORD_FRAC_BITS = tps_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire                                      clk,
  input  wire                                      rst,
  input  wire                                      wr_en,
  input  wire  logic [tps_pkg::CFG_IDX_W-1:0]      wr_index,
  input  wire  logic [tps_pkg::COORD_W-1:0]        wr_data,
  input  wire                                      in_valid,
  output logic                                     in_ready,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] first_x,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] first_y,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] first_z,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] second_x,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] second_y,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] second_z,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] third_x,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] third_y,
  input  wire  logic signed [tps_pkg::COORD_W-1:0] third_z,
  input  wire                                      batch_start,
  output logic                                     out_valid,
  input  wire                                      out_ready,
  output logic                                     side,
  output logic signed [tps_pkg::COORD_W-1:0]       pos_x,
  output logic signed [tps_pkg::COORD_W-1:0]       pos_y,
  output logic signed [tps_pkg::COORD_W-1:0]       pos_z,
  output logic [tps_pkg::IDX_W-1:0]                list_index,
  output logic [2:0]                               polygon_size,
  output logic                                     fan_indexed,
  output logic                                     list_full,
  output logic                                     last
);

  localparam int D_W = 67 - COORD_FRAC_BITS;
  localparam longint unsigned DEPTH_USED = (LIST_DEPTH > 64'd65536) ? 64'd65536 : LIST_DEPTH;
  localparam logic [tps_pkg::IDX_W-1:0] FULL_AT = tps_pkg::IDX_W'(DEPTH_USED - 64'd1);

  localparam int CW = tps_pkg::COORD_W;

  // configuration
  logic signed [CW-1:0]           nrm [3];
  logic signed [CW-1:0]           pnt [3];
  logic [tps_pkg::TOL_W-1:0]      tolerance;

  // triangle state
  tps_pkg::state_t                state;
  tps_pkg::state_t                state_next;
  logic signed [CW-1:0]           vx [3][3];
  logic signed [CW-1:0]           ipx [3][3];
  logic signed [D_W-1:0]          sdist [3];
  tps_pkg::cls_t                  cl_w [3];
  tps_pkg::plist_t                plist;
  tps_pkg::plist_t                plist_w;
  logic [3:0]                     sz_front;
  logic [3:0]                     sz_back;
  logic [3:0]                     szf_w;
  logic [3:0]                     szb_w;
  logic [1:0]                     vtx;
  logic [1:0]                     crd;
  logic [1:0]                     edg;
  logic [1:0]                     edg_b;
  logic [2:0]                     k;
  logic [tps_pkg::IDX_W-1:0]      front_vertex_count;
  logic [tps_pkg::IDX_W-1:0]      back_vertex_count;

  // shared units
  logic signed [tps_pkg::DIFF_W-1:0] mul_b;
  logic signed [tps_pkg::PROD_W-1:0] prod;
  logic signed [D_W-1:0]             term;
  logic                              div_start;
  logic [D_W-1:0]                    a_mag;
  logic [D_W:0]                      den;
  logic signed [D_W:0]               ddiff;
  logic signed [tps_pkg::DIFF_W-1:0] delta;
  logic [tps_pkg::DIFF_W-1:0]        b_mag;
  tps_pkg::div_stat_t                div_st;
  logic [tps_pkg::QUOT_W-1:0]        quot;
  logic signed [tps_pkg::QUOT_W-1:0] ip_val;

  logic signed [D_W-1:0]          tol_p;
  logic signed [D_W-1:0]          tol_n;
  logic                           crossing;
  logic                           emit_go;
  tps_pkg::entry_t                ent;
  logic [tps_pkg::IDX_W-1:0]      cnt_sel;
  logic                           full_w;
  logic [3:0]                     sz_sel;

  tps_mul u_mul (
    .clk  (clk),
    .a    (nrm[crd]),
    .b    (mul_b),
    .prod (prod)
  );

  tps_div #(
    .D_W (D_W)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .a_mag  (a_mag),
    .b_mag  (b_mag),
    .den    (den),
    .status (div_st),
    .quot   (quot)
  );

  always_comb begin
    mul_b = tps_pkg::DIFF_W'(vx[vtx][crd]) - tps_pkg::DIFF_W'(pnt[crd]);
    // arithmetic shift floors the Q32.32 product to a Q34.16 term
    term  = D_W'(prod >>> COORD_FRAC_BITS);
    tol_p = $signed({{(D_W - tps_pkg::TOL_W){1'b0}}, tolerance});
    tol_n = -tol_p;
    for (int i = 0; i < 3; i++) begin
      if (sdist[i] > tol_p) cl_w[i] = tps_pkg::CL_FRONT;
      else if (sdist[i] < tol_n) cl_w[i] = tps_pkg::CL_BEHIND;
      else cl_w[i] = tps_pkg::CL_ON;
    end
    plist_w = tps_pkg::build_list(cl_w[0], cl_w[1], cl_w[2]);
    szf_w = '0;
    szb_w = '0;
    for (int m = 0; m < tps_pkg::MAX_EMIT; m++) begin
      if (4'(m) < plist_w.count) begin
        if (plist_w.ent[m].side) szb_w = szb_w + 4'd1;
        else szf_w = szf_w + 4'd1;
      end
    end
  end

  // crossing-point operands for edge edg, coordinate crd
  always_comb begin
    edg_b    = (edg == 2'd2) ? 2'd0 : edg + 2'd1;
    a_mag    = sdist[edg][D_W-1] ? D_W'(-sdist[edg]) : D_W'(sdist[edg]);
    ddiff    = (D_W+1)'(sdist[edg]) - (D_W+1)'(sdist[edg_b]);
    den      = ddiff[D_W] ? (D_W+1)'(-ddiff) : (D_W+1)'(ddiff);
    delta    = tps_pkg::DIFF_W'(vx[edg_b][crd]) - tps_pkg::DIFF_W'(vx[edg][crd]);
    b_mag    = delta[tps_pkg::DIFF_W-1] ? tps_pkg::DIFF_W'(-delta) : tps_pkg::DIFF_W'(delta);
    ip_val   = delta[tps_pkg::DIFF_W-1] ?
               tps_pkg::QUOT_W'(vx[edg][crd]) - $signed(quot) :
               tps_pkg::QUOT_W'(vx[edg][crd]) + $signed(quot);
    crossing = (cl_w[edg] == tps_pkg::CL_FRONT && cl_w[edg_b] == tps_pkg::CL_BEHIND) ||
               (cl_w[edg] == tps_pkg::CL_BEHIND && cl_w[edg_b] == tps_pkg::CL_FRONT);
  end

  // emit selection
  always_comb begin
    ent     = plist.ent[k];
    cnt_sel = ent.side ? back_vertex_count : front_vertex_count;
    full_w  = (cnt_sel >= FULL_AT);
    sz_sel  = ent.side ? sz_back : sz_front;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= tps_pkg::S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    emit_go    = 1'b0;
    case (state)
      tps_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = tps_pkg::S_MUL;
      end
      tps_pkg::S_MUL: state_next = tps_pkg::S_ACC;
      tps_pkg::S_ACC: begin
        if (vtx == 2'd2 && crd == 2'd2) state_next = tps_pkg::S_CLASS;
        else state_next = tps_pkg::S_MUL;
      end
      tps_pkg::S_CLASS: state_next = tps_pkg::S_DSETUP;
      tps_pkg::S_DSETUP: begin
        if (crossing) begin
          div_start  = 1'b1;
          state_next = tps_pkg::S_DWAIT;
        end else if (edg == 2'd2) begin
          state_next = tps_pkg::S_EMIT;
        end
      end
      tps_pkg::S_DWAIT: begin
        if (div_st.done) begin
          if (crd == 2'd2 && edg == 2'd2) state_next = tps_pkg::S_EMIT;
          else state_next = tps_pkg::S_DSETUP;
        end
      end
      tps_pkg::S_EMIT: begin
        emit_go = !out_valid || out_ready;
        if (emit_go && ({1'b0, k} == plist.count - 4'd1)) state_next = tps_pkg::S_IDLE;
      end
      default: state_next = tps_pkg::S_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0]    <= '0;
      nrm[1]    <= CW'(65536);
      nrm[2]    <= '0;
      pnt[0]    <= '0;
      pnt[1]    <= '0;
      pnt[2]    <= '0;
      tolerance <= tps_pkg::TOL_W'(66);
    end else if (wr_en) begin
      case (wr_index)
        tps_pkg::REG_NORMAL_X:  nrm[0]    <= wr_data;
        tps_pkg::REG_NORMAL_Y:  nrm[1]    <= wr_data;
        tps_pkg::REG_NORMAL_Z:  nrm[2]    <= wr_data;
        tps_pkg::REG_POINT_X:   pnt[0]    <= wr_data;
        tps_pkg::REG_POINT_Y:   pnt[1]    <= wr_data;
        tps_pkg::REG_POINT_Z:   pnt[2]    <= wr_data;
        tps_pkg::REG_TOLERANCE: tolerance <= wr_data[tps_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      front_vertex_count <= '0;
      back_vertex_count  <= '0;
      out_valid          <= 1'b0;
      vtx                <= '0;
      crd                <= '0;
      edg                <= '0;
      k                  <= '0;
    end else begin
      // load a new vertex, or hold the current one until its transfer
      out_valid <= (state == tps_pkg::S_EMIT && emit_go) || (out_valid && !out_ready);
      case (state)
        tps_pkg::S_IDLE: begin
          if (in_valid) begin
            vx[0][0] <= first_x;
            vx[0][1] <= first_y;
            vx[0][2] <= first_z;
            vx[1][0] <= second_x;
            vx[1][1] <= second_y;
            vx[1][2] <= second_z;
            vx[2][0] <= third_x;
            vx[2][1] <= third_y;
            vx[2][2] <= third_z;
            for (int i = 0; i < 3; i++) sdist[i] <= '0;
            vtx <= '0;
            crd <= '0;
            if (batch_start) begin
              front_vertex_count <= '0;
              back_vertex_count  <= '0;
            end
          end
        end
        tps_pkg::S_ACC: begin
          sdist[vtx] <= sdist[vtx] + term;
          if (crd == 2'd2) begin
            crd <= '0;
            vtx <= vtx + 2'd1;
          end else begin
            crd <= crd + 2'd1;
          end
        end
        tps_pkg::S_CLASS: begin
          plist    <= plist_w;
          sz_front <= szf_w;
          sz_back  <= szb_w;
          edg      <= '0;
          crd      <= '0;
          k        <= '0;
        end
        tps_pkg::S_DSETUP: begin
          // skip an edge that does not straddle the plane
          if (!crossing && edg != 2'd2) begin
            edg <= edg + 2'd1;
            crd <= '0;
          end
        end
        tps_pkg::S_DWAIT: begin
          if (div_st.done) begin
            ipx[edg][crd] <= ip_val[CW-1:0];
            if (crd == 2'd2) begin
              crd <= '0;
              if (edg != 2'd2) edg <= edg + 2'd1;
            end else begin
              crd <= crd + 2'd1;
            end
          end
        end
        tps_pkg::S_EMIT: begin
          if (emit_go) begin
            side         <= ent.side;
            list_index   <= cnt_sel;
            polygon_size <= sz_sel[2:0];
            fan_indexed  <= (sz_sel == 4'd3) || (sz_sel == 4'd4);
            list_full    <= full_w;
            last         <= ({1'b0, k} == plist.count - 4'd1);
            case (ent.src)
              tps_pkg::SRC_V0: {pos_x, pos_y, pos_z} <= {vx[0][0], vx[0][1], vx[0][2]};
              tps_pkg::SRC_V1: {pos_x, pos_y, pos_z} <= {vx[1][0], vx[1][1], vx[1][2]};
              tps_pkg::SRC_V2: {pos_x, pos_y, pos_z} <= {vx[2][0], vx[2][1], vx[2][2]};
              tps_pkg::SRC_I0: {pos_x, pos_y, pos_z} <= {ipx[0][0], ipx[0][1], ipx[0][2]};
              tps_pkg::SRC_I1: {pos_x, pos_y, pos_z} <= {ipx[1][0], ipx[1][1], ipx[1][2]};
              tps_pkg::SRC_I2: {pos_x, pos_y, pos_z} <= {ipx[2][0], ipx[2][1], ipx[2][2]};
              default:         {pos_x, pos_y, pos_z} <= {vx[0][0], vx[0][1], vx[0][2]};
            endcase
            // hold the last slot once the list is full
            if (!full_w) begin
              if (ent.side) back_vertex_count <= back_vertex_count + tps_pkg::IDX_W'(1);
              else front_vertex_count <= front_vertex_count + tps_pkg::IDX_W'(1);
            end
            k <= k + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/tps_mul.sv */
// ----------------------------------------------------------------------------
// tps_mul: shared signed multiplier
// Multiplies a normal component by a vertex offset; product is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_mul (
  input  wire                                        clk,
  input  wire  logic signed [tps_pkg::COORD_W-1:0]   a,
  input  wire  logic signed [tps_pkg::DIFF_W-1:0]    b,
  output logic signed [tps_pkg::PROD_W-1:0]          prod
);

  always_ff @(posedge clk) begin
    prod <= tps_pkg::PROD_W'(a) * tps_pkg::PROD_W'(b);
  end

endmodule

`default_nettype wire

/* rtl/tps_div.sv */
// ----------------------------------------------------------------------------
// tps_div: iterative multiply-divide unit
// Computes floor(a * b / den) one bit of b per cycle, keeping the remainder
// below den; requires a < den so each step yields a quotient digit of 0..2.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_div #(
  parameter int D_W = 51
) (
  input  wire                                    clk,
  input  wire                                    rst,
  input  wire                                    start,
  input  wire  logic [D_W-1:0]                   a_mag,
  input  wire  logic [tps_pkg::DIFF_W-1:0]       b_mag,
  input  wire  logic [D_W:0]                     den,
  output tps_pkg::div_stat_t                     status,
  output logic [tps_pkg::QUOT_W-1:0]             quot
);

  localparam int R_W = D_W + 3;

  logic [R_W-1:0]                      rem;
  logic [tps_pkg::DIFF_W-1:0]          bsh;
  logic [tps_pkg::DIV_CNT_W-1:0]       cnt;
  logic                                busy;
  logic                                done;
  logic [R_W-1:0]                      t;
  logic [R_W-1:0]                      den1;
  logic [R_W-1:0]                      den2;

  always_comb begin
    den1 = R_W'(den);
    den2 = R_W'({den, 1'b0});
    t    = {rem[R_W-2:0], 1'b0} + (bsh[tps_pkg::DIFF_W-1] ? R_W'(a_mag) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= tps_pkg::DIV_CNT_W'(tps_pkg::DIV_STEPS);
        rem  <= '0;
        quot <= '0;
        bsh  <= b_mag;
      end else if (busy) begin
        bsh <= {bsh[tps_pkg::DIFF_W-2:0], 1'b0};
        if (t >= den2) begin
          rem  <= t - den2;
          quot <= {quot[tps_pkg::QUOT_W-2:0], 1'b0} + tps_pkg::QUOT_W'(2);
        end else if (t >= den1) begin
          rem  <= t - den1;
          quot <= {quot[tps_pkg::QUOT_W-2:0], 1'b1};
        end else begin
          rem  <= t;
          quot <= {quot[tps_pkg::QUOT_W-2:0], 1'b0};
        end
        cnt <= cnt - tps_pkg::DIV_CNT_W'(1);
        if (cnt == tps_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for triangle_plane_split_core
// Drives triangles over a valid/ready channel under several plane settings,
// predicts every emitted vertex (side, position, list index, flags) and
// checks the output stream in order, with random idling and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 260;
  localparam int HOLD_CYCLES    = 400;

  typedef struct {
    logic signed [31:0] x [3];
    logic signed [31:0] y [3];
    logic signed [31:0] z [3];
    logic               batch;
  } tri_t;

  typedef struct packed {
    logic        side;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    logic [15:0] idx;
    logic [2:0]  psize;
    logic        fan;
    logic        full;
    logic        last;
  } vtx_out_t;

  typedef struct {
    logic   side;
    longint c [3];
  } pend_vtx_t;

  class split_scoreboard;
    logic signed [31:0] nrm [3];
    logic signed [31:0] pnt [3];
    logic [30:0]        tol;
    logic [15:0]        front_cnt;
    logic [15:0]        back_cnt;
    vtx_out_t           expected_vtx [$];
    pend_vtx_t          emit_list [$];
    int                 errors;

    function new();
      nrm[0] = 0; nrm[1] = 32'sd65536; nrm[2] = 0;
      pnt[0] = 0; pnt[1] = 0; pnt[2] = 0;
      tol = 31'd66;
      front_cnt = 0;
      back_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [tps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
      case (idx)
        tps_pkg::REG_NORMAL_X:  nrm[0] = val;
        tps_pkg::REG_NORMAL_Y:  nrm[1] = val;
        tps_pkg::REG_NORMAL_Z:  nrm[2] = val;
        tps_pkg::REG_POINT_X:   pnt[0] = val;
        tps_pkg::REG_POINT_Y:   pnt[1] = val;
        tps_pkg::REG_POINT_Z:   pnt[2] = val;
        tps_pkg::REG_TOLERANCE: tol = val[30:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_vtx.size();
    endfunction

    function longint plane_dist(longint v [3]);
      longint d;
      d = 0;
      for (int c = 0; c < 3; c++)
        d += (longint'(nrm[c]) * (v[c] - longint'(pnt[c]))) >>>
             tps_pkg::COORD_FRAC_BITS_DEF;
      return d;
    endfunction

    function void add_vtx(logic s, longint v [3]);
      pend_vtx_t e;
      if (emit_list.size() >= tps_pkg::MAX_EMIT) return;
      e.side = s;
      e.c = v;
      emit_list = {emit_list, e};
    endfunction

    // Crossing point, exact: a + sgn(delta) * floor(|da|*|delta| / |da-db|).
    function void crossing(longint a [3], longint da, longint b [3], longint db,
                           output longint ip [3]);
      logic [127:0] num;
      logic [127:0] den;
      logic [127:0] q;
      longint       delta;
      num = 0;
      den = (da - db < 0) ? -(da - db) : (da - db);
      for (int c = 0; c < 3; c++) begin
        delta = b[c] - a[c];
        num = 128'((da < 0) ? -da : da) * 128'((delta < 0) ? -delta : delta);
        q = num / den;
        ip[c] = (delta < 0) ? a[c] - longint'(q[63:0]) : a[c] + longint'(q[63:0]);
      end
    endfunction

    function void split_edge(longint a [3], longint da, tps_pkg::cls_t ca,
                             longint b [3], longint db, tps_pkg::cls_t cb);
      longint ip [3];
      if (cb == tps_pkg::CL_FRONT) begin
        if (ca == tps_pkg::CL_BEHIND) begin
          crossing(a, da, b, db, ip);
          add_vtx(tps_pkg::SIDE_FRONT, ip);
          add_vtx(tps_pkg::SIDE_FRONT, b);
          add_vtx(tps_pkg::SIDE_BACK, ip);
        end else begin
          add_vtx(tps_pkg::SIDE_FRONT, b);
        end
      end else if (cb == tps_pkg::CL_ON) begin
        add_vtx(tps_pkg::SIDE_FRONT, b);
        if (ca == tps_pkg::CL_BEHIND) add_vtx(tps_pkg::SIDE_BACK, b);
      end else begin
        if (ca == tps_pkg::CL_FRONT) begin
          crossing(a, da, b, db, ip);
          add_vtx(tps_pkg::SIDE_FRONT, ip);
          add_vtx(tps_pkg::SIDE_BACK, ip);
        end else if (ca == tps_pkg::CL_ON) begin
          add_vtx(tps_pkg::SIDE_BACK, a);
        end
        add_vtx(tps_pkg::SIDE_BACK, b);
      end
    endfunction

    function void note_triangle(tri_t t);
      longint        v [3][3];
      longint        d [3];
      tps_pkg::cls_t cl [3];
      int            nf, nb, j;
      int            sz [2];
      vtx_out_t      r;
      logic          full;
      if (t.batch) begin
        front_cnt = 0;
        back_cnt = 0;
      end
      nf = 0;
      nb = 0;
      for (int i = 0; i < 3; i++) begin
        v[i][0] = t.x[i];
        v[i][1] = t.y[i];
        v[i][2] = t.z[i];
        d[i] = plane_dist(v[i]);
        cl[i] = (d[i] > longint'(tol)) ? tps_pkg::CL_FRONT :
                (d[i] < -longint'(tol)) ? tps_pkg::CL_BEHIND : tps_pkg::CL_ON;
        if (cl[i] == tps_pkg::CL_FRONT) nf++;
        if (cl[i] == tps_pkg::CL_BEHIND) nb++;
      end
      emit_list.delete();
      if (nb == 3) begin
        for (int i = 0; i < 3; i++) add_vtx(tps_pkg::SIDE_BACK, v[i]);
      end else if (nf == 3 || (nf == 0 && nb == 0)) begin
        for (int i = 0; i < 3; i++) add_vtx(tps_pkg::SIDE_FRONT, v[i]);
      end else begin
        for (int i = 0; i < 3; i++) begin
          j = (i == 2) ? 0 : i + 1;
          split_edge(v[i], d[i], cl[i], v[j], d[j], cl[j]);
        end
      end
      sz[0] = 0;
      sz[1] = 0;
      foreach (emit_list[k]) sz[emit_list[k].side]++;
      foreach (emit_list[k]) begin
        r.side  = emit_list[k].side;
        r.px    = emit_list[k].c[0][31:0];
        r.py    = emit_list[k].c[1][31:0];
        r.pz    = emit_list[k].c[2][31:0];
        r.idx   = r.side ? back_cnt : front_cnt;
        r.psize = sz[r.side][2:0];
        r.fan   = (sz[r.side] == 3 || sz[r.side] == 4);
        full    = (r.idx == 16'hFFFF);
        r.full  = full;
        r.last  = (k == emit_list.size() - 1);
        if (!full) begin
          if (r.side) back_cnt++;
          else front_cnt++;
        end
        expected_vtx = {expected_vtx, r};
      end
    endfunction

    function void check_vertex(vtx_out_t got);
      vtx_out_t want;
      if (expected_vtx.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: vertex with nothing expected: %p", got);
        return;
      end
      want = expected_vtx.pop_front();
      if (got.side !== want.side || got.px !== want.px || got.py !== want.py ||
          got.pz !== want.pz || got.idx !== want.idx || got.psize !== want.psize ||
          got.fan !== want.fan || got.full !== want.full || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR at %0t: vertex mismatch", $realtime);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic wr_en;
  logic [tps_pkg::CFG_IDX_W-1:0] wr_index;
  logic [31:0] wr_data;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] first_x, first_y, first_z, second_x, second_y, second_z;
  logic signed [31:0] third_x, third_y, third_z;
  logic batch_start;
  logic side, fan_indexed, list_full, last;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [15:0] list_index;
  logic [2:0] polygon_size;

  split_scoreboard sb;
  logic quiet;
  logic hold_req;
  int   hold_left;
  int   stall_cycles;

  triangle_plane_split_core DUT (
    .clk(clk), .rst(rst),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_x(first_x), .first_y(first_y), .first_z(first_z),
    .second_x(second_x), .second_y(second_y), .second_z(second_z),
    .third_x(third_x), .third_y(third_y), .third_z(third_z),
    .batch_start(batch_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .side(side), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .list_index(list_index), .polygon_size(polygon_size),
    .fan_indexed(fan_indexed), .list_full(list_full), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Note transfers on both channels and keep the stall watchdog.
  always @(posedge clk) begin
    tri_t t;
    if (!rst) begin
      if (in_valid && in_ready) begin
        t.x[0] = first_x;  t.y[0] = first_y;  t.z[0] = first_z;
        t.x[1] = second_x; t.y[1] = second_y; t.z[1] = second_z;
        t.x[2] = third_x;  t.y[2] = third_y;  t.z[2] = third_z;
        t.batch = batch_start;
        sb.note_triangle(t);
      end
      if (out_valid && out_ready)
        sb.check_vertex({side, pos_x, pos_y, pos_z, list_index, polygon_size,
                         fan_indexed, list_full, last});
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("ERROR: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("** triangle_plane_split_core: FAILED **");
        $finish;
      end
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = quiet || ($urandom_range(99) >= 13);
      end
    end
  end

  task automatic write_reg(logic [tps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    wr_en = 1'b1;
    wr_index = idx;
    wr_data = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    wr_en = 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
                           logic [31:0] tl);
    drain();
    write_reg(tps_pkg::REG_NORMAL_X, nx);
    write_reg(tps_pkg::REG_NORMAL_Y, ny);
    write_reg(tps_pkg::REG_NORMAL_Z, nz);
    write_reg(tps_pkg::REG_POINT_X, qx);
    write_reg(tps_pkg::REG_POINT_Y, qy);
    write_reg(tps_pkg::REG_POINT_Z, qz);
    write_reg(tps_pkg::REG_TOLERANCE, tl);
  endtask

  // Offer one triangle at the falling edge and hold it until the transfer.
  task automatic send_tri(tri_t t);
    int gap;
    @(negedge clk);
    gap = 0;
    if (!quiet && $urandom_range(99) < 13) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    first_x = t.x[0];  first_y = t.y[0];  first_z = t.z[0];
    second_x = t.x[1]; second_y = t.y[1]; second_z = t.z[1];
    third_x = t.x[2];  third_y = t.y[2];  third_z = t.z[2];
    batch_start = t.batch;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Reset plane is y = 0, so the y coordinate alone sets each class.
  function automatic tri_t tri_by_y(logic signed [31:0] y0, logic signed [31:0] y1,
                                    logic signed [31:0] y2, logic b);
    tri_t t;
    t.y[0] = y0; t.y[1] = y1; t.y[2] = y2;
    for (int i = 0; i < 3; i++) begin
      t.x[i] = $urandom_range(32'h0010_0000);
      t.z[i] = -$signed($urandom_range(32'h0010_0000));
    end
    t.batch = b;
    return t;
  endfunction

  // Vertices scattered near the plane point; some sit exactly on it.
  function automatic tri_t tri_near(int span);
    tri_t t;
    for (int i = 0; i < 3; i++) begin
      if ($urandom_range(4) == 0) begin
        t.x[i] = sb.pnt[0]; t.y[i] = sb.pnt[1]; t.z[i] = sb.pnt[2];
      end else begin
        t.x[i] = sb.pnt[0] + $signed($urandom_range(2 * span)) - span;
        t.y[i] = sb.pnt[1] + $signed($urandom_range(2 * span)) - span;
        t.z[i] = sb.pnt[2] + $signed($urandom_range(2 * span)) - span;
      end
    end
    t.batch = ($urandom_range(15) == 0);
    return t;
  endfunction

  function automatic tri_t tri_wide();
    tri_t t;
    for (int i = 0; i < 3; i++) begin
      t.x[i] = $urandom; t.y[i] = $urandom; t.z[i] = $urandom;
    end
    t.batch = $urandom_range(1);
    return t;
  endfunction

  function automatic logic [31:0] rnd_signed(int mag);
    return $signed($urandom_range(2 * mag)) - mag;
  endfunction

  initial begin
    tri_t t;
    sb = new();
    rst = 1'b1;
    wr_en = 1'b0; wr_index = '0; wr_data = '0;
    in_valid = 1'b0;
    first_x = 0; first_y = 0; first_z = 0;
    second_x = 0; second_y = 0; second_z = 0;
    third_x = 0; third_y = 0; third_z = 0;
    batch_start = 1'b0;
    quiet = 1'b0;
    hold_req = 1'b0;
    stall_cycles = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: whole sides, coplanar, tolerance edges and every split shape.
    send_tri(tri_by_y(32'sd65536, 32'sd67, 32'sd131072, 1'b1));
    send_tri(tri_by_y(-32'sd65536, -32'sd67, -32'sd900000, 1'b0));
    send_tri(tri_by_y(32'sd0, 32'sd66, -32'sd66, 1'b0));
    send_tri(tri_by_y(32'sd65536, 32'sd0, 32'sd0, 1'b0));
    send_tri(tri_by_y(32'sd0, 32'sd65536, 32'sd0, 1'b0));
    send_tri(tri_by_y(32'sd65536, 32'sd65536, -32'sd65536, 1'b0));
    send_tri(tri_by_y(-32'sd65536, 32'sd65536, 32'sd65536, 1'b0));
    send_tri(tri_by_y(32'sd65536, -32'sd65536, -32'sd65536, 1'b0));
    send_tri(tri_by_y(-32'sd65536, -32'sd65536, 32'sd65536, 1'b0));
    send_tri(tri_by_y(32'sd65536, 32'sd0, -32'sd65536, 1'b0));
    send_tri(tri_by_y(-32'sd65536, 32'sd0, 32'sd65536, 1'b0));
    send_tri(tri_by_y(32'sd0, -32'sd65536, -32'sd65536, 1'b0));
    send_tri(tri_by_y(32'sd0, 32'sd0, -32'sd65536, 1'b1));
    send_tri(tri_by_y(-32'sd65536, 32'sd0, 32'sd0, 1'b0));
    t = tri_by_y(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    t.x[0] = 32'h8000_0000; t.x[1] = 32'h7FFF_FFFF; t.x[2] = 32'h8000_0000;
    t.z[0] = 32'h7FFF_FFFF; t.z[1] = 32'h8000_0000; t.z[2] = 32'h0;
    send_tri(t);
    t = tri_by_y(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    send_tri(t);
    stop_sending();

    // Moderate random plane; a long hold-off and a full pause midway.
    set_plane(rnd_signed(1 << 17), rnd_signed(1 << 17), rnd_signed(1 << 17),
              rnd_signed(1 << 24), rnd_signed(1 << 24), rnd_signed(1 << 24),
              $urandom_range(1 << 18));
    for (int n = 0; n < 90; n++) begin
      if (n == 30) hold_req = 1'b1;
      if (n == 55) begin
        stop_sending();
        while (sb.pending() != 0) @(posedge clk);
      end
      quiet = (n >= 65 && n < 85);
      send_tri(tri_near(1 << 20));
    end
    quiet = 1'b0;
    stop_sending();

    // Extreme normal and full-range vertices, zero tolerance.
    set_plane(32'h7FFF_FFFF, 32'h8000_0000, $urandom, $urandom, $urandom, $urandom, 32'h0);
    for (int n = 0; n < 45; n++) send_tri(tri_wide());
    stop_sending();

    // Widest tolerance: many vertices fall in the coplanar band.
    set_plane($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 32'h7FFF_FFFF);
    for (int n = 0; n < 15; n++) send_tri(tri_wide());
    stop_sending();

    // Small tolerance, unit-ish normal, dense batches.
    set_plane(rnd_signed(1 << 16), 32'sd65536, rnd_signed(1 << 16),
              rnd_signed(1 << 20), rnd_signed(1 << 20), rnd_signed(1 << 20),
              $urandom_range(200));
    for (int n = 0; n < 45; n++) send_tri(tri_near(1 << 18));
    stop_sending();

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** triangle_plane_split_core: PASSED **");
    end else begin
      if (sb.pending() != 0) $display("ERROR: %0d vertices never arrived", sb.pending());
      $display("** triangle_plane_split_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
